/* hdl/srf_pkg.sv */
// ----------------------------------------------------------------------------
// srf_pkg: shared types and constants of the sub-record framer
// Holds the item structs, the action codes and the state encoding of the
// framer's control sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package srf_pkg;

  // Largest number of units in one sub-record.
  localparam int unsigned MaxUnits = 63;
  // Width of the unit count and of a data store address.
  localparam int unsigned CntW = 6;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxUnits);

  // Action codes of an input item.
  localparam logic [1:0] ActAdd   = 2'd0;
  localparam logic [1:0] ActClose = 2'd1;
  localparam logic [1:0] ActEnd   = 2'd2;

  // Input item: one action and its data byte.
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
  } srf_in_t;

  // Result item: one emitted byte and the end-of-burst mark.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_burst;
  } srf_out_t;

  // Control sequencer states.
  typedef enum logic {
    StIdle,
    StSend
  } state_e;

endpackage

`default_nettype wire

/* hdl/subrecord_rle_framer.sv */
// An item that sends nothing is done in the cycle it is accepted. A header goes
// from the header register to the output register when the output is free, and
// data bytes follow via the read buffer, one a cycle unless the output stalls.
// Throughput: one item a cycle when nothing is sent, else no new item until the
// burst is out, paced by the data store read port (one byte read per cycle).
// Reset clears count, run flag, config and handshake state, not the data store.
// ----------------------------------------------------------------------------
// subrecord_rle_framer: sub-record run-length framer
// Packs data bytes into sub-records of a header byte and up to 63 data bytes,
// with optional run-length compression of repeated bytes. The open
// sub-record's bytes live in a 63-entry synchronous memory that is streamed
// out through a one-entry read buffer into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module subrecord_rle_framer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire srf_pkg::srf_in_t   in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output srf_pkg::srf_out_t       out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_wdata_i
);

  localparam int unsigned AW = srf_pkg::CntW;

  // Architectural state of the open sub-record.
  logic          comp_q;
  logic [AW-1:0] cnt_q, cnt_d;
  logic          run_q, run_d;
  logic [7:0]    last_q, last_d;

  // Sequencer and burst state.
  srf_pkg::state_e state_q, state_d;
  logic [7:0]    hdr_q, hdr_d;
  logic [AW-1:0] len_q, len_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic          hdr_done_q, hdr_done_d;
  logic          post_we_q, post_we_d;
  logic          buf_full_q, buf_full_d;

  // Output register.
  logic              out_valid_q, out_valid_d;
  srf_pkg::srf_out_t out_q, out_d;

  // Data store ports.
  logic [7:0]    data_mem [srf_pkg::MaxUnits];
  logic [7:0]    rdata_q;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  // Decision for the item at the input.
  logic          dec_send;
  logic          dec_end;
  logic          dec_hdr_run;
  logic [AW-1:0] dec_hdr_cnt;
  logic [AW-1:0] dec_len;
  logic          dec_pre_we;
  logic          dec_post_we;
  logic [AW-1:0] cnt_inc;
  logic          same_byte;

  logic accept;
  logic out_free;
  logic buf_take;
  logic send_done;

  assign in_ready_o  = (state_q == srf_pkg::StIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  assign cnt_inc   = AW'(cnt_q + 1'b1);
  assign same_byte = (in_data_i.data_byte == last_q);

  // Work out what the item at the input does to the open sub-record.
  always_comb begin
    dec_send    = 1'b0;
    dec_end     = 1'b0;
    dec_hdr_run = run_q;
    dec_hdr_cnt = cnt_q;
    dec_len     = run_q ? AW'(1) : cnt_q;
    dec_pre_we  = 1'b0;
    dec_post_we = 1'b0;
    cnt_d       = cnt_q;
    run_d       = run_q;
    last_d      = last_q;
    unique case (in_data_i.action)
      srf_pkg::ActClose: begin
        if (cnt_q != '0) begin
          dec_send = 1'b1;
          cnt_d    = '0;
          run_d    = 1'b0;
        end
      end
      srf_pkg::ActEnd: begin
        dec_send = 1'b1;
        dec_end  = 1'b1;
        cnt_d    = '0;
        run_d    = 1'b0;
      end
      srf_pkg::ActAdd: begin
        last_d = in_data_i.data_byte;
        if (run_q && (!comp_q || !same_byte)) begin
          // A run ends: send it, then the byte opens a literal sub-record.
          dec_send    = 1'b1;
          dec_post_we = 1'b1;
          cnt_d       = AW'(1);
          run_d       = 1'b0;
        end else if (run_q) begin
          // The run grows by one; a full run is sent.
          cnt_d = cnt_inc;
          if (cnt_inc == srf_pkg::MaxCnt) begin
            dec_send    = 1'b1;
            dec_hdr_cnt = cnt_inc;
            cnt_d       = '0;
            run_d       = 1'b0;
          end
        end else if (comp_q && (cnt_q != '0) && same_byte) begin
          // Second equal byte: earlier literals go out, a run starts.
          run_d = 1'b1;
          cnt_d = AW'(2);
          if (cnt_q != AW'(1)) begin
            dec_send    = 1'b1;
            dec_hdr_cnt = AW'(cnt_q - 1'b1);
            dec_len     = AW'(cnt_q - 1'b1);
            dec_post_we = 1'b1;
          end
        end else begin
          // Literal append; a full sub-record is sent.
          dec_pre_we = 1'b1;
          cnt_d      = cnt_inc;
          if (cnt_inc == srf_pkg::MaxCnt) begin
            dec_send    = 1'b1;
            dec_hdr_cnt = cnt_inc;
            dec_len     = cnt_inc;
            cnt_d       = '0;
          end
        end
      end
      default: begin
        last_d = last_q;
      end
    endcase
  end

  // Burst sequencer: header first, then the stored bytes through the buffer.
  always_comb begin
    state_d     = state_q;
    hdr_d       = hdr_q;
    len_d       = len_q;
    rd_idx_d    = rd_idx_q;
    hdr_done_d  = hdr_done_q;
    post_we_d   = post_we_q;
    buf_full_d  = buf_full_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    mem_re      = 1'b0;
    buf_take    = 1'b0;
    send_done   = 1'b0;
    unique case (state_q)
      srf_pkg::StIdle: begin
        if (accept && dec_send) begin
          state_d    = srf_pkg::StSend;
          hdr_d      = {dec_end, dec_hdr_run, dec_hdr_cnt};
          len_d      = dec_len;
          rd_idx_d   = '0;
          hdr_done_d = 1'b0;
          post_we_d  = dec_post_we;
          buf_full_d = 1'b0;
        end
      end
      srf_pkg::StSend: begin
        buf_take = buf_full_q && hdr_done_q && out_free;
        mem_re   = (rd_idx_q != len_q) && (!buf_full_q || buf_take);
        if (mem_re) begin
          rd_idx_d   = AW'(rd_idx_q + 1'b1);
          buf_full_d = 1'b1;
        end else if (buf_take) begin
          buf_full_d = 1'b0;
        end
        if (!hdr_done_q && out_free) begin
          hdr_done_d          = 1'b1;
          out_valid_d         = 1'b1;
          out_d.out_byte      = hdr_q;
          out_d.last_of_burst = (len_q == '0);
          send_done           = (len_q == '0);
        end else if (buf_take) begin
          out_valid_d         = 1'b1;
          out_d.out_byte      = rdata_q;
          out_d.last_of_burst = (rd_idx_q == len_q);
          send_done           = (rd_idx_q == len_q);
        end
        if (send_done) begin
          state_d = srf_pkg::StIdle;
        end
      end
      default: begin
        state_d = srf_pkg::StIdle;
      end
    endcase
  end

  // Store writes: appends before a send at accept, the deferred byte after it.
  assign mem_we    = (accept && dec_pre_we) || (send_done && post_we_q);
  assign mem_waddr = accept ? cnt_q : '0;
  assign mem_wdata = accept ? in_data_i.data_byte : last_q;

  // Data store, one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= data_mem[rd_idx_q];
    end
    if (mem_we) begin
      data_mem[mem_waddr] <= mem_wdata;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_q      <= 1'b0;
      cnt_q       <= '0;
      run_q       <= 1'b0;
      state_q     <= srf_pkg::StIdle;
      rd_idx_q    <= '0;
      hdr_done_q  <= 1'b0;
      post_we_q   <= 1'b0;
      buf_full_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        comp_q <= cfg_wdata_i;
      end
      if (accept) begin
        cnt_q <= cnt_d;
        run_q <= run_d;
      end
      state_q     <= state_d;
      rd_idx_q    <= rd_idx_d;
      hdr_done_q  <= hdr_done_d;
      post_we_q   <= post_we_d;
      buf_full_q  <= buf_full_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      last_q <= last_d;
    end
    hdr_q <= hdr_d;
    len_q <= len_d;
    out_q <= out_d;
  end

`ifndef ASSERT_OFF
  // At rest the open sub-record is never full.
  a_cnt_below_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != srf_pkg::MaxCnt)
    else $error("open sub-record holds the maximum count");

  // An open run always covers at least two bytes.
  a_run_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> (cnt_q >= AW'(2)))
    else $error("run open with fewer than two bytes");

  // Reads never pass the burst length.
  a_rd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == srf_pkg::StSend) |-> (rd_idx_q <= len_q))
    else $error("data store read beyond burst length");

  // Before the header leaves, at most one byte is read ahead.
  a_read_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == srf_pkg::StSend) && !hdr_done_q) |-> (rd_idx_q <= AW'(1)))
    else $error("read ahead of header exceeds buffer");
`endif

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the sub-record run-length framer
// Drives a short table of directed items and then random phases of data
// runs, literal stretches, closes and record ends. Each phase uses its own
// compression setting. A mirror of the framer's count, run flag and data
// store predicts the bytes that the table does not type. Both handshakes idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  // Action code that the framer ignores.
  localparam logic [1:0] ActNone = 2'd3;
  localparam int SettleCycles = 4;
  localparam int TailCycles = 20;
  localparam int QuietLimit = 500;
  localparam int RandomItems = 230;
  localparam int PhaseItems = 40;
  // Marks a table row whose results come from the mirror.
  localparam int Predicted = -1;

  typedef struct {
    logic              comp;
    srf_pkg::srf_in_t  item;
    int                n_typed;
    logic [7:0]        b0;
    logic [7:0]        b1;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  srf_pkg::srf_in_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  srf_pkg::srf_out_t out_data;
  logic              cfg_we = 1'b0;
  logic              cfg_wdata = 1'b0;

  // Mirror of the framer state.
  logic       comp_en = 1'b0;
  logic [5:0] fr_cnt = '0;
  logic       fr_run = 1'b0;
  logic [7:0] fr_store [0:62];

  srf_pkg::srf_out_t exp_bytes [$];
  stim_row_t         dir_rows [$];
  int        n_errors = 0;
  int        quiet = 0;
  int        out_hold = 0;
  int        real_items = 0;
  bit        calm = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  subrecord_rle_framer u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  // Idle cycles before the next item on either side.
  function automatic int draw_wait();
    return calm ? 0 : int'($urandom_range(0, 6));
  endfunction

  function automatic srf_pkg::srf_in_t mk(logic [1:0] act, logic [7:0] b);
    srf_pkg::srf_in_t it;
    it.action = act;
    it.data_byte = b;
    return it;
  endfunction

  function automatic stim_row_t row(logic comp, logic [1:0] act, logic [7:0] b,
                                    int n, logic [7:0] b0, logic [7:0] b1);
    stim_row_t r;
    r.comp = comp;
    r.item = mk(act, b);
    r.n_typed = n;
    r.b0 = b0;
    r.b1 = b1;
    return r;
  endfunction

  // Queue the open sub-record, header first, and empty it.
  function automatic void send_sub(logic end_flag);
    int stored;
    srf_pkg::srf_out_t b;
    stored = fr_run ? 1 : int'(fr_cnt);
    b.out_byte = {end_flag, fr_run, fr_cnt};
    b.last_of_burst = 1'b0;
    exp_bytes.push_back(b);
    for (int i = 0; i < stored; i++) begin
      b.out_byte = fr_store[i];
      exp_bytes.push_back(b);
    end
    fr_cnt = '0;
    fr_run = 1'b0;
  endfunction

  function automatic void store_byte(logic [7:0] c);
    fr_store[fr_cnt] = c;
    fr_cnt = fr_cnt + 6'd1;
  endfunction

  // One added byte, literal or run-length coded.
  function automatic void add_byte(logic [7:0] c);
    if (!comp_en) begin
      if (fr_run) send_sub(1'b0);
      store_byte(c);
      if (fr_cnt == srf_pkg::MaxCnt) send_sub(1'b0);
    end else if (fr_cnt == '0) begin
      fr_run = 1'b0;
      store_byte(c);
    end else if (fr_run) begin
      if (c == fr_store[0]) begin
        fr_cnt = fr_cnt + 6'd1;
        if (fr_cnt == srf_pkg::MaxCnt) send_sub(1'b0);
      end else begin
        send_sub(1'b0);
        store_byte(c);
      end
    end else if (c != fr_store[fr_cnt - 6'd1]) begin
      store_byte(c);
      if (fr_cnt == srf_pkg::MaxCnt) send_sub(1'b0);
    end else begin
      // A repeated byte sends the earlier literals and opens a run.
      if (fr_cnt != 6'd1) begin
        fr_cnt = fr_cnt - 6'd1;
        send_sub(1'b0);
        store_byte(c);
      end
      fr_run = 1'b1;
      fr_cnt = fr_cnt + 6'd1;
    end
  endfunction

  // Expected bytes of one accepted item; returns how many were queued.
  function automatic int frame_step(srf_pkg::srf_in_t it);
    int n_before;
    srf_pkg::srf_out_t tail;
    n_before = exp_bytes.size();
    case (it.action)
      srf_pkg::ActAdd:   add_byte(it.data_byte);
      srf_pkg::ActClose: if (fr_cnt != '0) send_sub(1'b0);
      srf_pkg::ActEnd:   send_sub(1'b1);
      default: ;
    endcase
    if (exp_bytes.size() > n_before) begin
      tail = exp_bytes.pop_back();
      tail.last_of_burst = 1'b1;
      exp_bytes.push_back(tail);
    end
    return exp_bytes.size() - n_before;
  endfunction

  // Offer one item and predict its results once it is taken.
  task automatic send_item(input srf_pkg::srf_in_t it, output int n_res);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    n_res = frame_step(it);
    if (it.action != ActNone) real_items++;
  endtask

  task automatic feed(input srf_pkg::srf_in_t it);
    int n_res;
    send_item(it, n_res);
  endtask

  // Wait until the framer is idle, then write the compression register.
  task automatic set_compression(input logic comp);
    in_valid <= 1'b0;
    while (exp_bytes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= comp;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    comp_en = comp;
  endtask

  // Output side: check each item and stall at random.
  always @(posedge clk_i) begin
    srf_pkg::srf_out_t want;
    if (rst_ni) begin
      if (out_ready && out_valid) begin
        if (exp_bytes.size() == 0) begin
          $error("unexpected item: out_byte %02h", out_data.out_byte);
          n_errors++;
        end else begin
          want = exp_bytes.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, out_data.out_byte);
            n_errors++;
          end
          if (out_data.last_of_burst !== want.last_of_burst) begin
            $error("last_of_burst: expected %0b, got %0b", want.last_of_burst,
                   out_data.last_of_burst);
            n_errors++;
          end
        end
        out_hold = draw_wait();
        out_ready <= (out_hold == 0);
      end else if (!out_ready) begin
        if (out_hold <= 1) out_ready <= 1'b1;
        out_hold--;
      end
    end
  end

  // Watchdog on cycles in which neither side moves an item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet <= 0;
      end else if (quiet == QuietLimit) begin
        $display("** subrecord_rle_framer: FAILED **");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    int n_res;
    int phase;
    int phase_end;
    int kind;
    int len;
    logic comp;
    logic [7:0] b;

    // Directed table: compression, action, byte, typed result count and bytes.
    dir_rows.push_back(row(1'b0, srf_pkg::ActEnd,   8'h00, 1, 8'h80, 8'h00));
    dir_rows.push_back(row(1'b0, srf_pkg::ActClose, 8'hFF, 0, 8'h00, 8'h00));
    dir_rows.push_back(row(1'b0, ActNone,           8'h5A, 0, 8'h00, 8'h00));
    dir_rows.push_back(row(1'b0, srf_pkg::ActAdd,   8'h00, 0, 8'h00, 8'h00));
    dir_rows.push_back(row(1'b0, srf_pkg::ActAdd,   8'hFF, 0, 8'h00, 8'h00));
    dir_rows.push_back(row(1'b0, srf_pkg::ActClose, 8'h00, Predicted, 8'h00, 8'h00));
    dir_rows.push_back(row(1'b0, srf_pkg::ActAdd,   8'hA5, 0, 8'h00, 8'h00));
    dir_rows.push_back(row(1'b0, srf_pkg::ActEnd,   8'h00, 2, 8'h81, 8'hA5));
    dir_rows.push_back(row(1'b1, srf_pkg::ActAdd,   8'h3C, 0, 8'h00, 8'h00));
    dir_rows.push_back(row(1'b1, srf_pkg::ActAdd,   8'h3C, 0, 8'h00, 8'h00));
    dir_rows.push_back(row(1'b1, srf_pkg::ActAdd,   8'h3C, 0, 8'h00, 8'h00));
    dir_rows.push_back(row(1'b1, srf_pkg::ActAdd,   8'hC3, 2, 8'h43, 8'h3C));
    dir_rows.push_back(row(1'b1, srf_pkg::ActAdd,   8'h11, 0, 8'h00, 8'h00));
    dir_rows.push_back(row(1'b1, srf_pkg::ActAdd,   8'h11, 2, 8'h01, 8'hC3));
    dir_rows.push_back(row(1'b1, srf_pkg::ActClose, 8'h00, 2, 8'h42, 8'h11));
    // Bytes that differ in a single bit must not start a run.
    dir_rows.push_back(row(1'b1, srf_pkg::ActAdd,   8'h7F, Predicted, 8'h00, 8'h00));
    dir_rows.push_back(row(1'b1, srf_pkg::ActAdd,   8'hFF, Predicted, 8'h00, 8'h00));
    dir_rows.push_back(row(1'b1, srf_pkg::ActAdd,   8'h7F, Predicted, 8'h00, 8'h00));
    dir_rows.push_back(row(1'b1, srf_pkg::ActAdd,   8'h7E, Predicted, 8'h00, 8'h00));
    dir_rows.push_back(row(1'b1, srf_pkg::ActEnd,   8'h00, Predicted, 8'h00, 8'h00));
    dir_rows.push_back(row(1'b1, srf_pkg::ActAdd,   8'h55, Predicted, 8'h00, 8'h00));
    dir_rows.push_back(row(1'b1, srf_pkg::ActAdd,   8'h55, Predicted, 8'h00, 8'h00));
    // Compression switched off with a run open: the run goes out first.
    dir_rows.push_back(row(1'b0, srf_pkg::ActAdd,   8'h55, 2, 8'h42, 8'h55));
    dir_rows.push_back(row(1'b0, srf_pkg::ActEnd,   8'hFF, 2, 8'h81, 8'h55));
    dir_rows.push_back(row(1'b1, srf_pkg::ActClose, 8'h00, 0, 8'h00, 8'h00));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].comp != comp_en) set_compression(dir_rows[i].comp);
      send_item(dir_rows[i].item, n_res);
      if (dir_rows[i].n_typed != Predicted) begin
        repeat (n_res) void'(exp_bytes.pop_back());
        if (dir_rows[i].n_typed >= 1)
          exp_bytes.push_back('{out_byte: dir_rows[i].b0,
                                last_of_burst: (dir_rows[i].n_typed == 1)});
        if (dir_rows[i].n_typed == 2)
          exp_bytes.push_back('{out_byte: dir_rows[i].b1, last_of_burst: 1'b1});
      end
    end

    // Random phases, each with its own compression setting.
    real_items = 0;
    phase = 0;
    while (real_items < RandomItems) begin
      case (phase)
        0: comp = 1'b1;
        1: comp = 1'b0;
        2: comp = 1'b1;
        default: comp = 1'($urandom_range(0, 1));
      endcase
      set_compression(comp);
      calm = (phase % 4 == 3);
      phase_end = real_items + PhaseItems;

      // The first phases fill a sub-record to its full count.
      if (phase == 0) begin
        b = 8'($urandom_range(0, 255));
        repeat ($urandom_range(66, 72)) feed(mk(srf_pkg::ActAdd, b));
      end else if (phase == 1) begin
        repeat ($urandom_range(66, 72))
          feed(mk(srf_pkg::ActAdd, 8'($urandom_range(0, 255))));
      end else if (phase == 2) begin
        b = 8'($urandom_range(0, 255));
        repeat ($urandom_range(66, 72)) begin
          b = b + 8'($urandom_range(1, 255));
          feed(mk(srf_pkg::ActAdd, b));
        end
      end

      while (real_items < phase_end) begin
        kind = $urandom_range(0, 9);
        if (kind <= 3) begin
          // A run of one byte, now and then a long one.
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
          b = 8'($urandom_range(0, 255));
          repeat (len) feed(mk(srf_pkg::ActAdd, b));
        end else if (kind <= 6) begin
          // Literal bytes, sometimes an extreme value that may repeat.
          len = $urandom_range(1, 10);
          repeat (len) begin
            if ($urandom_range(0, 3) == 0)
              b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else
              b = 8'($urandom_range(0, 255));
            feed(mk(srf_pkg::ActAdd, b));
          end
        end else if (kind == 7) begin
          feed(mk(srf_pkg::ActClose, 8'($urandom_range(0, 255))));
        end else if (kind == 8) begin
          feed(mk(srf_pkg::ActEnd, 8'($urandom_range(0, 255))));
        end else begin
          feed(mk(ActNone, 8'($urandom_range(0, 255))));
        end
      end
      phase++;
    end

    // Let every expected byte come out, then give the framer a margin.
    in_valid <= 1'b0;
    while (exp_bytes.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("** subrecord_rle_framer: PASSED **");
    end else begin
      $display("** subrecord_rle_framer: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
hdl/srf_pkg.sv
hdl/subrecord_rle_framer.sv
tb/tb.sv
